[hdl/lcdseq_pkg.sv]
`default_nettype none

package lcdseq_pkg;

    localparam int unsigned CMD_W      = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned NIB_W      = 4;
    localparam int unsigned ROW_W      = 2;
    localparam int unsigned US_W       = 16;
    localparam int unsigned WAIT_W     = 15;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned INIT_CMDS  = 10;
    localparam int unsigned INIT_IDX_W = 4;

    localparam logic [US_W-1:0] ENABLE_HIGH_RESET = 16'd1000;
    localparam logic [US_W-1:0] SETTLE_RESET      = 16'd2000;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 2'd1;

    localparam logic [BYTE_W-1:0] DIGIT_OFFSET = 8'h30;
    localparam logic [BYTE_W-1:0] ROW1_BASE    = 8'h80;
    localparam logic [BYTE_W-1:0] ROW2_BASE    = 8'hC0;
    localparam logic [ROW_W-1:0]  FIRST_ROW    = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSTR  = 3'd0,
        CMD_DATA   = 3'd1,
        CMD_DIGIT  = 3'd2,
        CMD_CURSOR = 3'd3,
        CMD_INIT   = 3'd4
    } cmd_t;

    // Four pin phases per byte: high nibble strobe/settle, low nibble strobe/settle
    typedef enum logic [1:0] {
        PH_HI_EN  = 2'd0,
        PH_HI_SET = 2'd1,
        PH_LO_EN  = 2'd2,
        PH_LO_SET = 2'd3
    } phase_t;

    typedef struct packed {
        logic                  open;
        logic                  init;
        logic [INIT_IDX_W-1:0] idx;
        phase_t                phase;
        logic [BYTE_W-1:0]     data_byte;
        logic                  rs;
    } seq_ctl_t;

    typedef struct packed {
        logic [NIB_W-1:0] nibble;
        logic             rs;
        logic             en;
        logic [US_W-1:0]  hold;
        logic             last;
    } phase_out_t;

    function automatic logic [BYTE_W-1:0] init_cmd(input logic [INIT_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            4'd0:    c = 8'h00;
            4'd1:    c = 8'h30;
            4'd2:    c = 8'h30;
            4'd3:    c = 8'h30;
            4'd4:    c = 8'h02;
            4'd5:    c = 8'h28;
            4'd6:    c = 8'h0C;
            4'd7:    c = 8'h06;
            4'd8:    c = 8'h01;
            4'd9:    c = 8'h80;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [WAIT_W-1:0] init_wait(input logic [INIT_IDX_W-1:0] idx);
        logic [WAIT_W-1:0] w;
        case (idx)
            4'd0:    w = 15'd20000;
            4'd1:    w = 15'd5000;
            4'd2:    w = 15'd100;
            4'd3:    w = 15'd0;
            4'd4:    w = 15'd2000;
            4'd5:    w = 15'd40;
            4'd6:    w = 15'd40;
            4'd7:    w = 15'd40;
            4'd8:    w = 15'd2000;
            4'd9:    w = 15'd40;
            default: w = 15'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hdl/char_lcd_nibble_write_sequencer_core.sv]
`default_nettype none

// Character LCD write sequencer for a 4-bit HD44780-style bus. Pulse start
// with cmd/value/row/col while busy is low; the request then plays out as
// one pin phase per clock on nibble/reg_select/enable with hold_us telling
// the pin driver how long to keep that phase. Each phase is a single-cycle
// beat marked by strobe, and there is no back-pressure: the receiver must
// take every beat as it comes. Command, data, digit and cursor requests
// give four beats (high nibble enable high, settle, low nibble enable high,
// settle); init gives 41 beats (one opening enable-high phase, then ten
// fixed instructions). last marks the final beat of a request. The
// sequencer counter is the only limit: one beat per clock. busy drops in
// the cycle before the final beat reaches the pins, so the next start is
// taken at the edge that puts the final beat out and its first beat
// follows right after. The first beat passes through the sequencer
// register, then the output register, before it reaches the pins. A cmd
// of 5, 6 or 7 is accepted and gives nothing.
// Write enable_high_us (index 0) and settle_us (index 1) over the cfg port
// only while idle; cfg_ready is always high.

module char_lcd_nibble_write_sequencer_core
    import lcdseq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [CMD_W-1:0]     cmd,
    input  wire logic [BYTE_W-1:0]    value,
    input  wire logic [ROW_W-1:0]     row,
    input  wire logic [BYTE_W-1:0]    col,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [US_W-1:0]      cfg_data,

    output logic                      strobe,
    output logic [NIB_W-1:0]          nibble,
    output logic                      reg_select,
    output logic                      enable,
    output logic [US_W-1:0]           hold_us,
    output logic                      last
);

    logic             active_reg, active_next;
    seq_ctl_t         ctl_reg, ctl_next;
    logic [US_W-1:0]  enable_high_reg;
    logic [US_W-1:0]  settle_reg;
    logic             strobe_reg;
    phase_out_t       out_reg;

    phase_out_t       ph;
    logic             final_phase;
    logic             accept;
    logic             cmd_ok;
    seq_ctl_t         load_ctl;
    logic [BYTE_W-1:0] cursor_base;

    lcdseq_phase_gen u_phase_gen (
        .ctl            (ctl_reg),
        .enable_high_us (enable_high_reg),
        .settle_us      (settle_reg),
        .ph             (ph),
        .final_phase    (final_phase)
    );

    // Take a new request during the final beat of the current one
    assign busy      = active_reg && !final_phase;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Decode an incoming request into sequencer control
    always_comb
    begin
        load_ctl           = '0;
        load_ctl.phase     = PH_HI_EN;
        cmd_ok             = 1'b1;
        cursor_base        = (row == FIRST_ROW) ? ROW1_BASE : ROW2_BASE;
        case (cmd)
            CMD_INSTR:
            begin
                load_ctl.data_byte = value;
            end
            CMD_DATA:
            begin
                load_ctl.data_byte = value;
                load_ctl.rs        = 1'b1;
            end
            CMD_DIGIT:
            begin
                load_ctl.data_byte = value + DIGIT_OFFSET;
                load_ctl.rs        = 1'b1;
            end
            CMD_CURSOR:
            begin
                // column counts from one; wraps modulo 256
                load_ctl.data_byte = cursor_base + col - 8'd1;
            end
            CMD_INIT:
            begin
                load_ctl.init = 1'b1;
                load_ctl.open = 1'b1;
            end
            default:
            begin
                cmd_ok = 1'b0;
            end
        endcase
    end

    // Advance through the phases of the current request
    always_comb
    begin
        ctl_next    = ctl_reg;
        active_next = active_reg;
        if (accept)
        begin
            ctl_next    = load_ctl;
            active_next = cmd_ok;
        end
        else if (active_reg)
        begin
            if (final_phase)
            begin
                // final beat with nothing new behind it: go idle
                active_next = 1'b0;
            end
            else if (ctl_reg.open)
            begin
                ctl_next.open = 1'b0;
            end
            else if (ctl_reg.phase == PH_LO_SET)
            begin
                ctl_next.phase = PH_HI_EN;
                ctl_next.idx   = ctl_reg.idx + INIT_IDX_W'(1);
            end
            else
            begin
                ctl_next.phase = phase_t'(ctl_reg.phase + 2'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            strobe_reg      <= 1'b0;
            enable_high_reg <= ENABLE_HIGH_RESET;
            settle_reg      <= SETTLE_RESET;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= active_reg;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ENABLE_HIGH: enable_high_reg <= cfg_data;
                    CFG_SETTLE:      settle_reg      <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // Payload registers: hold the decoded request and the beat on the pins
    always_ff @(posedge clk)
    begin
        ctl_reg <= ctl_next;
        out_reg <= ph;
    end

    assign strobe     = strobe_reg;
    assign nibble     = out_reg.nibble;
    assign reg_select = out_reg.rs;
    assign enable     = out_reg.en;
    assign hold_us    = out_reg.hold;
    assign last       = out_reg.last;

    // An idle sequencer produces no beat on the next clock
    a_idle_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |=> !strobe)
        else $error("beat emitted while sequencer idle");

    // The final beat of a request is always a settle phase
    a_last_is_settle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !enable)
        else $error("last beat has enable high");

    // A settle beat that is not final is followed at once by an enable pulse
    a_settle_then_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !enable && !last |=> strobe && enable)
        else $error("request run broken after settle beat");

    // A valid request is picked up by the sequencer on the next clock
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd == CMD_INSTR || cmd == CMD_DATA || cmd == CMD_DIGIT
            || cmd == CMD_CURSOR || cmd == CMD_INIT) |=> active_reg)
        else $error("accepted request not started");

endmodule

`default_nettype wire

[hdl/lcdseq_phase_gen.sv]
`default_nettype none

module lcdseq_phase_gen
    import lcdseq_pkg::*;
(
    input  wire seq_ctl_t         ctl,
    input  wire logic [US_W-1:0]  enable_high_us,
    input  wire logic [US_W-1:0]  settle_us,
    output phase_out_t            ph,
    output logic                  final_phase
);

    logic [BYTE_W-1:0] byte_sel;
    logic [WAIT_W-1:0] extra;
    logic [US_W:0]     settle_sum;
    logic [US_W-1:0]   settle_hold;
    logic              last_byte;
    logic              en;

    always_comb
    begin
        byte_sel    = ctl.init ? init_cmd(ctl.idx) : ctl.data_byte;
        extra       = ctl.init ? init_wait(ctl.idx) : '0;
        settle_sum  = {1'b0, settle_us} + {{(US_W + 1 - WAIT_W){1'b0}}, extra};
        // saturate the extended settle time at the field maximum
        settle_hold = settle_sum[US_W] ? '1 : settle_sum[US_W-1:0];
        last_byte   = !ctl.init || (ctl.idx == INIT_IDX_W'(INIT_CMDS - 1));
        en          = (ctl.phase == PH_HI_EN) || (ctl.phase == PH_LO_EN);

        if (ctl.open)
        begin
            ph.nibble   = '0;
            ph.rs       = 1'b0;
            ph.en       = 1'b1;
            ph.hold     = enable_high_us;
            ph.last     = 1'b0;
            final_phase = 1'b0;
        end
        else
        begin
            ph.nibble   = ((ctl.phase == PH_HI_EN) || (ctl.phase == PH_HI_SET))
                          ? byte_sel[BYTE_W-1:NIB_W] : byte_sel[NIB_W-1:0];
            ph.rs       = ctl.rs;
            ph.en       = en;
            ph.hold     = en ? enable_high_us
                        : ((ctl.phase == PH_LO_SET) ? settle_hold : settle_us);
            final_phase = (ctl.phase == PH_LO_SET) && last_byte;
            ph.last     = final_phase;
        end
    end

endmodule

`default_nettype wire
